FILE: hw/rtl/assert_macros.svh
// Assertion macros for the RTL files.
// No dependencies; included by the top level, which carries concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, off during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

FILE: hw/rtl/blzd_pkg.sv
// Shared types, constants and helpers for the backward LZ bitstream decoder.
// No dependencies; imported by blzd_ctrl, blzd_dp, the top level and the testbench files.
package blzd_pkg;

  localparam int unsigned HISTORY_DEPTH    = 16384;
  localparam int unsigned MAX_OUT_PER_ITEM = 64;

  localparam int unsigned HIST_AW = $clog2(HISTORY_DEPTH);
  localparam int unsigned OB_AW   = (MAX_OUT_PER_ITEM > 1) ? $clog2(MAX_OUT_PER_ITEM) : 1;
  localparam int unsigned OB_NW   = $clog2(MAX_OUT_PER_ITEM + 1);

  localparam int unsigned OFFSET_BITS = 13;
  localparam logic [7:0]  LEN_BYTE_CONT = 8'd255;
  localparam logic [31:0] LEN3_ESC  = 32'd3;
  localparam logic [31:0] LEN5_ESC  = 32'd10;
  localparam logic [31:0] LENB_ESC  = 32'd41;
  localparam logic [31:0] MIN_MATCH = 32'd3;

  localparam logic OP_PUSH  = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  typedef enum logic [2:0] {
    PH_FLAG = 3'd0,
    PH_LIT  = 3'd1,
    PH_OFF  = 3'd2,
    PH_LEN2 = 3'd3,
    PH_LEN3 = 3'd4,
    PH_LEN5 = 3'd5,
    PH_LENB = 3'd6,
    PH_COPY = 3'd7
  } phase_t;

  // Controller -> datapath
  typedef struct packed {
    logic load_in;     // input beat accepted
    logic step;        // one parse step or literal
    logic copy_rd;     // history read for a match byte
    logic copy_wr;     // match byte lands
    logic emit_start;  // fetch first buffered result
    logic emit_next;   // result beat taken, fetch next
  } dp_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic can_prog;
    logic is_copy;
    logic out_phase;   // copy or literal: produces a byte
    logic full;        // per-item byte budget used up
    logic rej;
    logic last;        // current result is the last of the item
  } dp_sts_t;

  // Bits a phase consumes before it can act.
  function automatic logic [3:0] phase_need(input phase_t ph);
    logic [3:0] n;
    case (ph)
      PH_FLAG: n = 4'd1;
      PH_LIT:  n = 4'd8;
      PH_OFF:  n = 4'd13;
      PH_LEN2: n = 4'd2;
      PH_LEN3: n = 4'd3;
      PH_LEN5: n = 4'd5;
      PH_LENB: n = 4'd8;
      default: n = 4'd0;
    endcase
    return n;
  endfunction

endpackage

FILE: hw/rtl/backward_lz_bitstream_decoder_top.sv
// Top level of the backward LZ bitstream decoder.
// Depends on blzd_pkg, blzd_ctrl, blzd_dp and assert_macros.svh.

// Decodes an LZ77-style stream fed from its end backwards, bits read MSB
// first, and returns the decompressed bytes last byte first. One input beat
// is handled at a time: in_ready is high only while the block is idle. After
// the beat is taken, the parser runs one step per cycle: each flag, offset
// or length field and each literal byte is one step, and a match byte takes
// a step for the history memory's registered read and then one for the write
// of the copied byte. The run stops when the buffered bits run short, when
// out_length bytes have been produced, or after MAX_OUT_PER_ITEM bytes. The
// result beats of the beat then leave at up to one per cycle from a small
// result buffer, every one carrying the status after the whole item
// (copy_pending, finished), so the first result appears only once the run is
// over. A beat that produces no byte gives one status beat with
// out_byte_valid low; a push while a copy is pending or after finishing is
// refused and flagged with out_rejected. An item passes through the accept
// of the beat, the run, a stop that fetches the first result, and the
// result beats. The history memory has no clearing pass: the decoder is
// usable right after reset. The user must write out_length through
// cfg_wr_en / cfg_wr_data only while the block is idle; the block itself
// does not enforce this.
module backward_lz_bitstream_decoder_top
  import blzd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  // compressed beat in
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_opcode,
  input  logic [7:0]  in_byte,
  // result beat out
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_byte_valid,
  output logic        out_last_in_run,
  output logic        out_copy_pending,
  output logic        out_finished,
  output logic        out_rejected
);

`include "assert_macros.svh"

  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencing: idle -> parse/copy run -> result beats -> idle
  blzd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // bit buffer, parser, history and result buffer
  blzd_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_opcode        (in_opcode),
    .in_byte          (in_byte),
    .cmd              (cmd),
    .sts              (sts),
    .out_byte         (out_byte),
    .out_byte_valid   (out_byte_valid),
    .out_last_in_run  (out_last_in_run),
    .out_copy_pending (out_copy_pending),
    .out_finished     (out_finished),
    .out_rejected     (out_rejected)
  );

  // input and output sides never open together
  `ASSERT_IMPLIES(a_no_overlap, clk, rst_n, in_ready, !out_valid)
  // a refused push yields exactly one status-only beat
  `ASSERT_IMPLIES(a_rej_status, clk, rst_n, out_valid && out_rejected,
                  !out_byte_valid && out_last_in_run)
  // finishing clears any pending copy
  `ASSERT_IMPLIES(a_fin_no_pend, clk, rst_n, out_valid && out_finished, !out_copy_pending)
  // taking the last beat frees the input side
  `ASSERT_NEXT(a_last_to_idle, clk, rst_n, out_valid && out_ready && out_last_in_run, in_ready)

endmodule

FILE: hw/rtl/blzd_ctrl.sv
// Sequencing state machine of the backward LZ decoder.
// Depends on blzd_pkg; drives commands into blzd_dp.
module blzd_ctrl
  import blzd_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_RUN  = 4'b0010,
    ST_COPY = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   stop;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_EMIT);

  assign stop = sts.rej || !sts.can_prog || (sts.out_phase && sts.full);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_RUN;
        end
      end
      ST_RUN: begin
        if (stop) begin
          cmd.emit_start = 1'b1;
          state_nxt      = ST_EMIT;
        end else if (sts.is_copy) begin
          cmd.copy_rd = 1'b1;
          state_nxt   = ST_COPY;
        end else begin
          cmd.step = 1'b1;
        end
      end
      ST_COPY: begin
        cmd.copy_wr = 1'b1;
        state_nxt   = ST_RUN;
      end
      ST_EMIT: begin
        if (out_ready) begin
          if (sts.last) begin
            state_nxt = ST_IDLE;
          end else begin
            cmd.emit_next = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: hw/rtl/blzd_dp.sv
// Datapath of the backward LZ decoder: bit buffer, parser fields, history
// memory and per-item result buffer. Depends on blzd_pkg; run by blzd_ctrl.
module blzd_dp
  import blzd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_opcode,
  input  logic [7:0]  in_byte,
  input  dp_cmd_t     cmd,
  output dp_sts_t     sts,
  output logic [7:0]  out_byte,
  output logic        out_byte_valid,
  output logic        out_last_in_run,
  output logic        out_copy_pending,
  output logic        out_finished,
  output logic        out_rejected
);

  logic [23:0]            buf_r, buf_nxt;
  logic [4:0]             cnt_r, cnt_nxt;
  phase_t                 phase_r, phase_nxt;
  logic [OFFSET_BITS-1:0] off_r, off_nxt;
  logic [31:0]            mlen_r, mlen_nxt;
  logic [31:0]            prod_r, prod_nxt;
  logic                   done_r, done_nxt;
  logic [31:0]            olen_r;
  logic [OB_NW-1:0]       n_r, n_nxt;
  logic [OB_AW-1:0]       k_r, k_nxt;
  logic                   rej_r, rej_nxt;

  logic [7:0] hist_mem [HISTORY_DEPTH];
  logic [7:0] hist_q;
  logic [7:0] ob_mem [MAX_OUT_PER_ITEM];
  logic [7:0] ob_q;

  logic               can_prog;
  logic [3:0]         need;
  logic [4:0]         cnt_take;
  logic [13:0]        take_mask;
  logic [12:0]        tb_val;
  logic [23:0]        buf_take;
  logic [31:0]        sum, sum3, mlen_dec, prod_inc;
  logic               emit;
  logic [7:0]         emit_byte;
  logic [HIST_AW-1:0] hist_rd_addr;
  logic [31:0]        src_pos;
  logic [OB_AW-1:0]   ob_rd_addr;

  // ---- parser status ----
  assign need     = phase_need(phase_r);
  assign can_prog = !done_r && ((phase_r == PH_COPY) || ({1'b0, cnt_r} >= {2'b0, need}));

  assign sts.can_prog  = can_prog;
  assign sts.is_copy   = (phase_r == PH_COPY);
  assign sts.out_phase = (phase_r == PH_COPY) || (phase_r == PH_LIT);
  assign sts.full      = (n_r == OB_NW'(MAX_OUT_PER_ITEM));
  assign sts.rej       = rej_r;
  assign sts.last      = (n_r == '0) || ({1'b0, k_r} == n_r - OB_NW'(1));

  // ---- take bits, MSB first ----
  assign cnt_take  = cnt_r - {1'b0, need};
  assign take_mask = (14'd1 << need) - 14'd1;
  assign tb_val    = 13'(buf_r >> cnt_take) & take_mask[12:0];
  assign buf_take  = buf_r & ~(24'hFFFFFF << cnt_take);

  assign sum      = mlen_r + {24'd0, tb_val[7:0]};
  assign sum3     = sum + MIN_MATCH;
  assign mlen_dec = mlen_r - 32'd1;
  assign prod_inc = prod_r + 32'd1;

  assign src_pos      = prod_r - {{(32-OFFSET_BITS){1'b0}}, off_r} - MIN_MATCH;
  assign hist_rd_addr = src_pos[HIST_AW-1:0];
  assign ob_rd_addr   = cmd.emit_next ? k_r + OB_AW'(1) : '0;

  always_comb begin
    buf_nxt   = buf_r;
    cnt_nxt   = cnt_r;
    phase_nxt = phase_r;
    off_nxt   = off_r;
    mlen_nxt  = mlen_r;
    prod_nxt  = prod_r;
    done_nxt  = done_r;
    n_nxt     = n_r;
    k_nxt     = k_r;
    rej_nxt   = rej_r;
    emit      = 1'b0;
    emit_byte = tb_val[7:0];

    if (cmd.load_in) begin
      n_nxt   = '0;
      rej_nxt = (in_opcode == OP_PUSH) && (done_r || can_prog);
      if ((in_opcode == OP_PUSH) && !(done_r || can_prog)) begin
        buf_nxt = {buf_r[15:0], in_byte};
        cnt_nxt = cnt_r + 5'd8;
      end
    end

    if (cmd.step) begin
      buf_nxt = buf_take;
      cnt_nxt = cnt_take;
      case (phase_r)
        PH_FLAG: phase_nxt = tb_val[0] ? PH_OFF : PH_LIT;
        PH_LIT: begin
          phase_nxt = PH_FLAG;
          emit      = 1'b1;
        end
        PH_OFF: begin
          off_nxt   = tb_val;
          phase_nxt = PH_LEN2;
        end
        PH_LEN2: begin
          if (sum == LEN3_ESC) begin
            mlen_nxt  = sum;
            phase_nxt = PH_LEN3;
          end else begin
            mlen_nxt  = sum3;
            phase_nxt = PH_COPY;
          end
        end
        PH_LEN3: begin
          if (sum == LEN5_ESC) begin
            mlen_nxt  = sum;
            phase_nxt = PH_LEN5;
          end else begin
            mlen_nxt  = sum3;
            phase_nxt = PH_COPY;
          end
        end
        PH_LEN5: begin
          if (sum == LENB_ESC) begin
            mlen_nxt  = sum;
            phase_nxt = PH_LENB;
          end else begin
            mlen_nxt  = sum3;
            phase_nxt = PH_COPY;
          end
        end
        PH_LENB: begin
          if (tb_val[7:0] == LEN_BYTE_CONT) begin
            mlen_nxt = sum;
          end else begin
            mlen_nxt  = sum3;
            phase_nxt = (sum3 == '0) ? PH_FLAG : PH_COPY;  // wrapped length
          end
        end
        default: phase_nxt = phase_r;
      endcase
    end

    if (cmd.copy_wr) begin
      mlen_nxt  = mlen_dec;
      phase_nxt = (mlen_dec == '0) ? PH_FLAG : PH_COPY;
      emit      = 1'b1;
      emit_byte = hist_q;
    end

    // emitted byte: count it, stop on reaching the configured length
    if (emit) begin
      prod_nxt = prod_inc;
      n_nxt    = n_r + OB_NW'(1);
      if (prod_inc == olen_r) begin
        done_nxt  = 1'b1;
        phase_nxt = PH_FLAG;
        mlen_nxt  = '0;
      end
    end

    if (cmd.emit_start) begin
      k_nxt = '0;
    end else if (cmd.emit_next) begin
      k_nxt = k_r + OB_AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_r   <= '0;
      cnt_r   <= '0;
      phase_r <= PH_FLAG;
      off_r   <= '0;
      mlen_r  <= '0;
      prod_r  <= '0;
      done_r  <= 1'b0;
      olen_r  <= 32'd1;
      n_r     <= '0;
      k_r     <= '0;
      rej_r   <= 1'b0;
    end else begin
      buf_r   <= buf_nxt;
      cnt_r   <= cnt_nxt;
      phase_r <= phase_nxt;
      off_r   <= off_nxt;
      mlen_r  <= mlen_nxt;
      prod_r  <= prod_nxt;
      done_r  <= done_nxt;
      n_r     <= n_nxt;
      k_r     <= k_nxt;
      rej_r   <= rej_nxt;
      if (cfg_wr_en) begin
        olen_r <= cfg_wr_data;
      end
    end
  end

  // history: written per emitted byte, read into hist_q in the cycle before the copy write
  always_ff @(posedge clk) begin
    if (emit) begin
      hist_mem[prod_r[HIST_AW-1:0]] <= emit_byte;
    end
    if (cmd.copy_rd) begin
      hist_q <= hist_mem[hist_rd_addr];
    end
  end

  // per-item result buffer; read data register doubles as the output byte
  always_ff @(posedge clk) begin
    if (emit) begin
      ob_mem[n_r[OB_AW-1:0]] <= emit_byte;
    end
    if (cmd.emit_start || cmd.emit_next) begin
      ob_q <= ob_mem[ob_rd_addr];
    end
  end

  assign out_byte_valid   = (n_r != '0);
  assign out_byte         = out_byte_valid ? ob_q : 8'd0;
  assign out_last_in_run  = sts.last;
  assign out_copy_pending = can_prog;
  assign out_finished     = done_r;
  assign out_rejected     = rej_r;

endmodule

FILE: verif/blzd_decode_monitor.sv
`timescale 1ns / 100ps
// Decode monitor for the backward LZ bitstream decoder testbench.
// Depends on blzd_pkg; watches the config port and both channels, predicts and compares beats.
module blzd_decode_monitor
  import blzd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_opcode,
  input  logic [7:0]  in_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_byte,
  input  logic        out_byte_valid,
  input  logic        out_last_in_run,
  input  logic        out_copy_pending,
  input  logic        out_finished,
  input  logic        out_rejected,
  output int          fail_count,
  output int          beats_owed
);

  typedef struct packed {
    logic [7:0] data;
    logic       data_vld;
    logic       last;
    logic       pend;
    logic       fin;
    logic       rej;
  } out_beat_t;

  // Predicted decoder state
  logic [31:0] len_limit;
  logic [23:0] bit_buf;
  logic [4:0]  bit_cnt;
  phase_t      ph;
  logic [12:0] match_off;
  logic [31:0] match_left;
  logic [31:0] prod_cnt;
  logic        done;
  logic [7:0]  hist [0:HISTORY_DEPTH-1];

  out_beat_t item_beats[$];
  out_beat_t decoded_beats_q[$];
  out_beat_t exp_b;
  int        mismatches = 0;
  int        owed = 0;

  assign fail_count = mismatches;
  assign beats_owed = owed;

  function automatic int unsigned bits_needed(phase_t p);
    case (p)
      PH_FLAG: return 1;
      PH_LIT:  return 8;
      PH_OFF:  return OFFSET_BITS;
      PH_LEN2: return 2;
      PH_LEN3: return 3;
      PH_LEN5: return 5;
      PH_LENB: return 8;
      default: return 0;
    endcase
  endfunction

  function automatic logic can_advance();
    if (done) return 1'b0;
    if (ph == PH_COPY) return 1'b1;
    return bit_cnt >= bits_needed(ph);
  endfunction

  function automatic logic [31:0] pull_bits(int unsigned n);
    logic [31:0] v;
    v = (32'(bit_buf) >> (bit_cnt - n)) & ((32'd1 << n) - 32'd1);
    bit_cnt = bit_cnt - 5'(n);
    bit_buf = bit_buf & 24'((32'd1 << bit_cnt) - 32'd1);
    return v;
  endfunction

  function automatic void emit_data(logic [7:0] d);
    out_beat_t bt;
    hist[prod_cnt % HISTORY_DEPTH] = d;
    prod_cnt = prod_cnt + 32'd1;
    bt = '0;
    bt.data = d;
    bt.data_vld = 1'b1;
    item_beats.push_back(bt);
    // reaching the limit drops whatever is left of a match
    if (prod_cnt == len_limit) begin
      done = 1'b1;
      ph = PH_FLAG;
      match_left = '0;
    end
  endfunction

  function automatic void start_match();
    match_left = match_left + MIN_MATCH;
    ph = (match_left == 32'd0) ? PH_FLAG : PH_COPY;
  endfunction

  function automatic void decode_item(logic op, logic [7:0] in_b);
    logic        rej;
    logic        pend_s;
    logic [31:0] v;
    logic [31:0] back_dist;
    logic [7:0]  d;
    phase_t      cur;
    out_beat_t   bt;
    rej = 1'b0;
    item_beats.delete();
    if (op == OP_PUSH) begin
      if (done || can_advance()) begin
        rej = 1'b1;
      end else begin
        bit_buf = {bit_buf[15:0], in_b};
        bit_cnt = bit_cnt + 5'd8;
      end
    end
    if (!rej) begin
      while (can_advance()) begin
        cur = ph;
        if ((cur == PH_COPY || cur == PH_LIT) && item_beats.size() >= MAX_OUT_PER_ITEM) break;
        if (cur == PH_COPY) begin
          back_dist = 32'(match_off) + MIN_MATCH;
          d = '0;
          if (prod_cnt >= back_dist) d = hist[(prod_cnt - back_dist) % HISTORY_DEPTH];
          match_left = match_left - 32'd1;
          if (match_left == 32'd0) ph = PH_FLAG;
          emit_data(d);
        end else begin
          v = pull_bits(bits_needed(cur));
          case (cur)
            PH_FLAG: ph = v[0] ? PH_OFF : PH_LIT;
            PH_LIT: begin
              ph = PH_FLAG;
              emit_data(v[7:0]);
            end
            PH_OFF: begin
              match_off = v[12:0];
              ph = PH_LEN2;
            end
            PH_LEN2: begin
              match_left = v;
              if (match_left == LEN3_ESC) ph = PH_LEN3;
              else start_match();
            end
            PH_LEN3: begin
              match_left = match_left + v;
              if (match_left == LEN5_ESC) ph = PH_LEN5;
              else start_match();
            end
            PH_LEN5: begin
              match_left = match_left + v;
              if (match_left == LENB_ESC) ph = PH_LENB;
              else start_match();
            end
            default: begin
              match_left = match_left + v;
              if (v[7:0] != LEN_BYTE_CONT) start_match();
            end
          endcase
        end
      end
    end
    if (item_beats.size() == 0) begin
      bt = '0;
      item_beats.push_back(bt);
    end
    pend_s = can_advance();
    foreach (item_beats[k]) begin
      item_beats[k].last = (k == item_beats.size() - 1);
      item_beats[k].pend = pend_s;
      item_beats[k].fin  = done;
      item_beats[k].rej  = rej;
      decoded_beats_q.push_back(item_beats[k]);
    end
  endfunction

  function automatic void check_field(string name, logic [7:0] expd, logic [7:0] act);
    if (act !== expd) begin
      $error("%s: expected %0h, actual %0h", name, expd, act);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      len_limit  = 32'd1;
      bit_buf    = '0;
      bit_cnt    = '0;
      ph         = PH_FLAG;
      match_off  = '0;
      match_left = '0;
      prod_cnt   = '0;
      done       = 1'b0;
      decoded_beats_q.delete();
    end else begin
      if (cfg_wr_en) len_limit = cfg_wr_data;
      if (out_valid && out_ready) begin
        if (decoded_beats_q.size() == 0) begin
          $error("result beat with none expected: out_byte %0h", out_byte);
          mismatches++;
        end else begin
          exp_b = decoded_beats_q.pop_front();
          check_field("out_byte", exp_b.data, out_byte);
          check_field("out_byte_valid", 8'(exp_b.data_vld), 8'(out_byte_valid));
          check_field("out_last_in_run", 8'(exp_b.last), 8'(out_last_in_run));
          check_field("out_copy_pending", 8'(exp_b.pend), 8'(out_copy_pending));
          check_field("out_finished", 8'(exp_b.fin), 8'(out_finished));
          check_field("out_rejected", 8'(exp_b.rej), 8'(out_rejected));
        end
      end
      if (in_valid && in_ready) decode_item(in_opcode, in_byte);
    end
    owed = decoded_beats_q.size();
  end

endmodule

FILE: verif/tb_backward_lz_bitstream_decoder_top.sv
`timescale 1ns / 100ps
// Top of the backward LZ bitstream decoder testbench: clock, reset, stimulus, verdict.
// Depends on blzd_pkg, backward_lz_bitstream_decoder_top and blzd_decode_monitor.
module tb_backward_lz_bitstream_decoder_top;
  import blzd_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [31:0] cfg_wr_data;
  logic        in_valid;
  logic        in_ready;
  logic        in_opcode;
  logic [7:0]  in_byte;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_byte;
  logic        out_byte_valid;
  logic        out_last_in_run;
  logic        out_copy_pending;
  logic        out_finished;
  logic        out_rejected;
  int          fail_count;
  int          beats_owed;

  // Status seen on the result side: items whose last beat has not left yet,
  // and the copy_pending / finished flags of the most recent last beat.
  int          items_open = 0;
  logic        last_pend = 1'b0;
  logic        last_fin = 1'b0;

  // Idle rates in percent per cycle, and the long hold-off request count.
  int          snd_idle_pct;
  int          rcv_idle_pct;
  int          hold_seq = 0;

  // Compressed stream under construction, bits in the order the decoder reads
  // them. planned_bytes is the decoded size of everything queued so far; it
  // bounds match offsets so a copy never reaches before the first byte.
  bit          stream_bits[$];
  logic [31:0] planned_bytes = '0;

  backward_lz_bitstream_decoder_top DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_byte          (in_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_byte_valid   (out_byte_valid),
    .out_last_in_run  (out_last_in_run),
    .out_copy_pending (out_copy_pending),
    .out_finished     (out_finished),
    .out_rejected     (out_rejected)
  );

  blzd_decode_monitor u_monitor (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_byte          (in_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_byte_valid   (out_byte_valid),
    .out_last_in_run  (out_last_in_run),
    .out_copy_pending (out_copy_pending),
    .out_finished     (out_finished),
    .out_rejected     (out_rejected),
    .fail_count       (fail_count),
    .beats_owed       (beats_owed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      items_open <= 0;
      last_pend  <= 1'b0;
      last_fin   <= 1'b0;
    end else begin
      items_open <= items_open + int'(in_valid && in_ready)
                    - int'(out_valid && out_ready && out_last_in_run);
      if (out_valid && out_ready && out_last_in_run) begin
        last_pend <= out_copy_pending;
        last_fin  <= out_finished;
      end
    end
  end

  // Result side: random back-pressure, plus a long hold-off on request.
  initial begin : result_sink
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  // MSB of v[n-1:0] goes first
  function automatic void put_bits(logic [31:0] v, int n);
    for (int i = n - 1; i >= 0; i--) stream_bits.push_back(v[i]);
  endfunction

  function automatic void add_literal(logic [7:0] d);
    put_bits(32'd0, 1);
    put_bits(32'(d), 8);
    planned_bytes = planned_bytes + 32'd1;
  endfunction

  // Match of len bytes (len >= 3) from distance off + 3; the length code is
  // split over the 2-, 3- and 5-bit fields and then continuation bytes.
  function automatic void add_match(logic [12:0] off, logic [31:0] len);
    logic [31:0] rest;
    put_bits(32'd1, 1);
    put_bits(32'(off), OFFSET_BITS);
    rest = len - MIN_MATCH;
    if (rest < LEN3_ESC) begin
      put_bits(rest, 2);
    end else begin
      put_bits(LEN3_ESC, 2);
      rest = rest - LEN3_ESC;
      if (rest < LEN5_ESC - LEN3_ESC) begin
        put_bits(rest, 3);
      end else begin
        put_bits(LEN5_ESC - LEN3_ESC, 3);
        rest = rest - (LEN5_ESC - LEN3_ESC);
        if (rest < LENB_ESC - LEN5_ESC) begin
          put_bits(rest, 5);
        end else begin
          put_bits(LENB_ESC - LEN5_ESC, 5);
          rest = rest - (LENB_ESC - LEN5_ESC);
          while (rest >= 32'(LEN_BYTE_CONT)) begin
            put_bits(32'(LEN_BYTE_CONT), 8);
            rest = rest - 32'(LEN_BYTE_CONT);
          end
          put_bits(rest, 8);
        end
      end
    end
    planned_bytes = planned_bytes + len;
  endfunction

  function automatic void add_random_token();
    logic [31:0] span;
    logic [31:0] len;
    logic [12:0] off;
    int          pick;
    if (planned_bytes < MIN_MATCH || $urandom_range(99) < 35) begin
      add_literal(8'($urandom_range(255)));
    end else begin
      span = planned_bytes - MIN_MATCH;
      if (span > 32'd8191) span = 32'd8191;
      // half near copies (runs), half anywhere in the reachable history
      if ($urandom_range(1)) off = 13'($urandom_range(span, 0));
      else off = 13'($urandom_range((span < 32'd15) ? span : 32'd15, 0));
      pick = $urandom_range(99);
      if (pick < 40)      len = $urandom_range(5, 3);
      else if (pick < 65) len = $urandom_range(12, 6);
      else if (pick < 85) len = $urandom_range(43, 13);
      else if (pick < 95) len = $urandom_range(298, 44);
      else                len = $urandom_range(1200, 299);
      add_match(off, len);
    end
  endfunction

  function automatic logic [7:0] next_stream_byte();
    logic [7:0] d;
    while (stream_bits.size() < 8) add_random_token();
    for (int i = 7; i >= 0; i--) d[i] = stream_bits.pop_front();
    return d;
  endfunction

  // Called at a falling edge; holds the beat until it is taken.
  task automatic drive_beat(logic op, logic [7:0] data);
    in_valid  <= 1'b1;
    in_opcode <= op;
    in_byte   <= data;
    do @(posedge clk); while (!in_ready);
  endtask

  // A stream byte is pushed only once the last item's beats are all out and
  // nothing is pending, so the stream never loses sync. Noise: pushes while a
  // copy is pending or after finishing (refused) and drains with nothing to do.
  // Under pressure, drains go out without waiting for the previous status.
  task automatic run_items(int count, int noise_pct, bit pressure);
    int sent;
    sent = 0;
    while (sent < count) begin
      @(negedge clk);
      if (items_open != 0 && !pressure) begin
        in_valid <= 1'b0;
      end else if ($urandom_range(99) < snd_idle_pct) begin
        in_valid <= 1'b0;
      end else if (items_open != 0) begin
        drive_beat(OP_DRAIN, 8'($urandom_range(255)));
        sent++;
      end else if (last_fin || last_pend) begin
        if ($urandom_range(99) < noise_pct) drive_beat(OP_PUSH, 8'($urandom_range(255)));
        else drive_beat(OP_DRAIN, 8'($urandom_range(255)));
        sent++;
      end else begin
        if ($urandom_range(99) < noise_pct / 2) drive_beat(OP_DRAIN, 8'($urandom_range(255)));
        else drive_beat(OP_PUSH, next_stream_byte());
        sent++;
      end
    end
  endtask

  // out_length only changes with the block idle and every beat out.
  task automatic write_length(logic [31:0] v);
    do begin
      @(negedge clk);
      in_valid <= 1'b0;
    end while (items_open != 0 || beats_owed != 0);
    repeat (4) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin : stimulus
    rst_n        = 1'b0;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = '0;
    in_valid     = 1'b0;
    in_opcode    = OP_PUSH;
    in_byte      = '0;
    snd_idle_pct = 15;
    rcv_idle_pct = 66;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Largest limit first; the reset value of 1 would finish on the first byte.
    write_length(32'hFFFF_FFFF);

    // Directed stream: literal extremes, then each length-code boundary -
    // shortest match, top of the 2-bit field, first 3-bit escape, first 5-bit
    // escape, top of the 5-bit field, first byte escape, and a continued byte
    // escape long enough to spill over many beats of 64 and need drains.
    add_literal(8'h00);
    add_literal(8'hFF);
    add_literal(8'h5A);
    add_match(13'd0, 32'd3);
    add_match(13'd2, 32'd5);
    add_match(13'd0, 32'd6);
    add_match(13'd1, 32'd13);
    add_match(13'd7, 32'd43);
    add_match(13'd0, 32'd44);
    add_match(13'd3, 32'd316);
    add_literal(8'h81);
    run_items(28, 30, 1'b0);

    // Random: sender idles lightly, receiver heavily.
    run_items(110, 8, 1'b0);
    write_length(32'd0);

    // Roles swapped.
    snd_idle_pct <= 66;
    rcv_idle_pct <= 15;
    run_items(130, 8, 1'b0);
    // Below the count already produced: never reached.
    write_length(32'd1);

    // No idling, then a long receiver hold-off while drains keep coming so
    // the block backs up and stalls its input.
    snd_idle_pct <= 0;
    rcv_idle_pct <= 0;
    run_items(60, 8, 1'b0);
    hold_seq <= hold_seq + 1;
    run_items(12, 0, 1'b1);
    write_length(planned_bytes + 32'd100000 + 32'($urandom_range(1 << 20)));
    run_items(50, 8, 1'b0);

    // Finish five bytes into a 30-byte match: the rest is dropped, and
    // later pushes are refused.
    write_length(planned_bytes + 32'd5);
    add_match(13'($urandom_range(4, 0)), 32'd30);
    run_items(16, 20, 1'b0);

    do begin
      @(negedge clk);
      in_valid <= 1'b0;
    end while (items_open != 0 || beats_owed != 0);
    // stray beats after the last expected one still get flagged
    repeat (200) @(posedge clk);
    if (fail_count == 0 && beats_owed == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
